// File: rtl/olst_pkg.sv
// shared types and constants for the ordered character list engine
package olst_pkg;

   // field widths of the command and result beats
   localparam int OP_W     = 3;
   localparam int LETTER_W = 8;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 2;
   localparam int FIDX_W   = 4;
   localparam int COUNT_W  = 5;

   // command codes; code 7 is unused and changes nothing
   typedef enum logic [OP_W-1:0] {
      OP_APPEND      = 3'd0,
      OP_PREPEND     = 3'd1,
      OP_INSERT_AT   = 3'd2,
      OP_REMOVE_LAST = 3'd3,
      OP_REMOVE_HEAD = 3'd4,
      OP_REMOVE_AT   = 3'd5,
      OP_FIND        = 3'd6
   } op_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // command beat
   typedef struct packed {
      op_type               op;
      logic [LETTER_W-1:0]  letter;
      logic [POS_W-1:0]     position;
   } req_type;

   // result beat
   typedef struct packed {
      status_type           status;
      logic                 found;
      logic [FIDX_W-1:0]    found_index;
      logic [COUNT_W-1:0]   count;
      logic                 is_empty;
   } rsp_type;

   // controller states
   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_INS_RD,
      S_INS_WR,
      S_REM_RD,
      S_REM_WR,
      S_FIND_RD,
      S_FIND_CMP,
      S_DONE
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic       load;
      logic       set_status;
      status_type status;
      logic       start_ins;
      logic       start_rem;
      logic       start_find;
      logic       rd_up;
      logic       wr_up;
      logic       rd_down;
      logic       wr_down;
      logic       put_letter;
      logic       dec_count;
      logic       step_find;
      logic       hit;
      logic       publish;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      op_type op;
      logic   full;
      logic   empty;
      logic   ins_more;
      logic   rem_more;
      logic   find_more;
      logic   match;
   } dp_stat_type;

endpackage

// File: rtl/olst_ram.sv
// generic single write, single read ram with registered read data
module olst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/olst_ctrl.sv
// sequencer for the list commands: dispatch, shift loops, search loop, result
module olst_ctrl
   import olst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output cmd_type     cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // state and result valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            case (stat.op)
               OP_APPEND, OP_PREPEND, OP_INSERT_AT: begin
                  state_in = stat.full ? S_DONE : S_INS_RD;
               end
               OP_REMOVE_LAST, OP_REMOVE_HEAD, OP_REMOVE_AT: begin
                  state_in = stat.empty ? S_DONE : S_REM_RD;
               end
               OP_FIND: begin
                  state_in = stat.empty ? S_DONE : S_FIND_RD;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_INS_RD:   state_in = stat.ins_more ? S_INS_WR : S_DONE;
         S_INS_WR:   state_in = S_INS_RD;
         S_REM_RD:   state_in = stat.rem_more ? S_REM_WR : S_DONE;
         S_REM_WR:   state_in = S_REM_RD;
         S_FIND_RD:  state_in = S_FIND_CMP;
         S_FIND_CMP: begin
            if (stat.match || !stat.find_more) state_in = S_DONE;
            else                               state_in = S_FIND_RD;
         end
         S_DONE: begin
            if (slot_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd          = '0;
      cmd.status   = ST_OK;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            cmd.load = req_valid;
         end
         S_DISPATCH: begin
            cmd.set_status = 1'b1;
            case (stat.op)
               OP_APPEND, OP_PREPEND, OP_INSERT_AT: begin
                  if (stat.full) cmd.status    = ST_FULL;
                  else           cmd.start_ins = 1'b1;
               end
               OP_REMOVE_LAST, OP_REMOVE_HEAD, OP_REMOVE_AT: begin
                  if (stat.empty) cmd.status    = ST_EMPTY;
                  else            cmd.start_rem = 1'b1;
               end
               OP_FIND: begin
                  if (stat.empty) cmd.status     = ST_EMPTY;
                  else            cmd.start_find = 1'b1;
               end
               default: cmd.status = ST_OK;
            endcase
         end
         S_INS_RD: begin
            if (stat.ins_more) cmd.rd_up      = 1'b1;
            else               cmd.put_letter = 1'b1;
         end
         S_INS_WR: cmd.wr_up = 1'b1;
         S_REM_RD: begin
            if (stat.rem_more) cmd.rd_down   = 1'b1;
            else               cmd.dec_count = 1'b1;
         end
         S_REM_WR:  cmd.wr_down = 1'b1;
         S_FIND_CMP: begin
            if (stat.match)          cmd.hit       = 1'b1;
            else if (stat.find_more) cmd.step_find = 1'b1;
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: cmd = '0;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/olst_dp.sv
// list datapath: entry store, count, cursor, index math and result register
module olst_dp
   import olst_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  cmd_type     cmd,
   output dp_stat_type stat,
   output rsp_type     rsp_data
);

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       cursor_ff, cursor_in;
   req_type             req_ff;
   status_type          status_ff;
   logic                found_ff;
   rsp_type             rsp_ff;

   logic [CW-1:0]       ins_idx, rem_idx, last_idx, pos_idx;
   logic                pos_past;
   logic                wr_en;
   logic [AW-1:0]       wr_addr, rd_addr;
   logic [LETTER_W-1:0] wr_data, rd_data;

   // target index math; position at or past the count means the tail
   assign pos_past = CMPW'(req_ff.position) >= CMPW'(count_ff);
   assign pos_idx  = CW'(req_ff.position);
   assign last_idx = count_ff - CW'(1);

   always_comb begin
      case (req_ff.op)
         OP_APPEND:    ins_idx = count_ff;
         OP_INSERT_AT: ins_idx = pos_past ? count_ff : pos_idx;
         default:      ins_idx = '0;
      endcase
      case (req_ff.op)
         OP_REMOVE_LAST: rem_idx = last_idx;
         OP_REMOVE_AT:   rem_idx = pos_past ? last_idx : pos_idx;
         default:        rem_idx = '0;
      endcase
   end

   // count and cursor updates
   always_comb begin
      count_in  = count_ff;
      cursor_in = cursor_ff;
      if (cmd.put_letter) count_in = count_ff + CW'(1);
      if (cmd.dec_count)  count_in = count_ff - CW'(1);
      if (cmd.start_ins)  cursor_in = count_ff;
      if (cmd.start_rem)  cursor_in = rem_idx;
      if (cmd.start_find) cursor_in = '0;
      if (cmd.wr_up)      cursor_in = cursor_ff - CW'(1);
      if (cmd.wr_down || cmd.step_find) cursor_in = cursor_ff + CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // working registers for the command in flight
   always_ff @(posedge clock) begin
      cursor_ff <= cursor_in;
      if (cmd.load) begin
         req_ff   <= req_data;
         found_ff <= 1'b0;
      end
      if (cmd.set_status) status_ff <= cmd.status;
      if (cmd.hit)        found_ff  <= 1'b1;
   end

   // entry store port selection
   always_comb begin
      wr_en   = cmd.wr_up || cmd.wr_down || cmd.put_letter;
      wr_addr = cmd.put_letter ? ins_idx[AW-1:0] : cursor_ff[AW-1:0];
      wr_data = cmd.put_letter ? req_ff.letter : rd_data;
      if (cmd.rd_up)        rd_addr = AW'(cursor_ff - CW'(1));
      else if (cmd.rd_down) rd_addr = AW'(cursor_ff + CW'(1));
      else                  rd_addr = cursor_ff[AW-1:0];
   end

   olst_ram #(
      .WIDTH (LETTER_W),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // status toward the sequencer
   always_comb begin
      stat.op        = req_ff.op;
      stat.full      = (count_ff == CW'(CAPACITY));
      stat.empty     = (count_ff == '0);
      stat.ins_more  = (cursor_ff > ins_idx);
      stat.rem_more  = ((CW + 1)'(cursor_ff) + (CW + 1)'(1)) < (CW + 1)'(count_ff);
      stat.find_more = stat.rem_more;
      stat.match     = (rd_data == req_ff.letter);
   end

   // result register, loaded once the command has settled
   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_ff.status      <= status_ff;
         rsp_ff.found       <= found_ff;
         rsp_ff.found_index <= found_ff ? FIDX_W'(cursor_ff) : '0;
         rsp_ff.count       <= COUNT_W'(count_ff);
         rsp_ff.is_empty    <= (count_ff == '0);
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// File: rtl/ordered_char_list_engine.sv
// top level of the ordered character list engine
//
// Bounded ordered list of byte characters, index 0 at the head.
// req channel: one beat is one command (append, prepend, insert at,
// remove last, remove first, remove at, find), with letter and position.
// rsp channel: one beat per command with status, found flag, found
// index, count after the command and an empty flag.
// Entries live in a single write, single read ram; every shift or search
// step has a read state and a write or compare state. A command passes
// through dispatch, its shift or search loop and a done state; rejected
// commands and the unused code skip the loop. The sequencer returns to
// idle as the result register is loaded.
// One command is in flight at a time; req_ready is high when the
// sequencer is idle, also while an earlier result still waits.
// If the receiver stalls, a finished command waits before loading the
// result register, and no new command is taken until it is loaded.
// Reset empties the list (count zero) and drops any pending result;
// entry contents are not cleared.
module ordered_char_list_engine
   import olst_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type     cmd;
   dp_stat_type stat;

   // sequencer
   olst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath with the entry store
   olst_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

// File: verif/olst_checker.sv
`timescale 1ns / 1ps
// list engine checker: follows both channels, predicts each answer and compares it
module olst_checker
   import olst_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending,
   output int      checked_count,
   output int      full_rejects,
   output int      empty_answers,
   output int      find_hits
);

   localparam int REPORT_LIMIT = 10;

   // shadow copy of the list, index 0 is the head
   logic [LETTER_W-1:0] list_bytes [CAPACITY];
   int unsigned         list_len = 0;

   // answers owed by the engine, oldest first
   rsp_type             answers_due [$];

   initial begin
      fail_count    = 0;
      pending       = 0;
      checked_count = 0;
      full_rejects  = 0;
      empty_answers = 0;
      find_hits     = 0;
   end

   // insert with slot clamped to the tail
   function automatic status_type place_letter(input int unsigned slot,
                                               input logic [LETTER_W-1:0] letter);
      int unsigned k;
      if (list_len >= CAPACITY) return ST_FULL;
      if (slot > list_len) slot = list_len;
      for (k = list_len; k > slot; k--) list_bytes[k] = list_bytes[k-1];
      list_bytes[slot] = letter;
      list_len++;
      return ST_OK;
   endfunction

   // removal with slot clamped to the tail
   function automatic status_type drop_entry(input int unsigned slot);
      int unsigned k;
      if (list_len == 0) return ST_EMPTY;
      if (slot >= list_len) slot = list_len - 1;
      for (k = slot; k + 1 < list_len; k++) list_bytes[k] = list_bytes[k+1];
      list_len--;
      return ST_OK;
   endfunction

   // apply one command to the shadow list and form its answer
   function automatic rsp_type apply_list_command(input req_type cmd);
      rsp_type     ans;
      int unsigned k;
      ans = '0;
      ans.status = ST_OK;
      case (cmd.op)
         OP_APPEND:      ans.status = place_letter(list_len, cmd.letter);
         OP_PREPEND:     ans.status = place_letter(0, cmd.letter);
         OP_INSERT_AT:   ans.status = place_letter(cmd.position, cmd.letter);
         // a slot past the end clamps to the tail
         OP_REMOVE_LAST: ans.status = drop_entry(list_len);
         OP_REMOVE_HEAD: ans.status = drop_entry(0);
         OP_REMOVE_AT:   ans.status = drop_entry(cmd.position);
         OP_FIND: begin
            if (list_len == 0) begin
               ans.status = ST_EMPTY;
            end else begin
               for (k = 0; k < list_len; k++) begin
                  if (list_bytes[k] == cmd.letter) begin
                     ans.found       = 1'b1;
                     ans.found_index = FIDX_W'(k);
                     break;
                  end
               end
            end
         end
         // unused code leaves the list alone
         default: ;
      endcase
      ans.count    = COUNT_W'(list_len);
      ans.is_empty = (list_len == 0);
      return ans;
   endfunction

   // beats are taken at the rising edge from values settled before it
   always @(posedge clock) begin : watch
      rsp_type due;
      rsp_type got;
      logic    bad;
      if (reset) begin
         list_len = 0;
         answers_due.delete();
      end else begin
         // result beat against the oldest owed answer
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (answers_due.size() == 0) begin
               if (fail_count < REPORT_LIMIT)
                  $display("%0t: result beat with nothing owed: %s%0d %0d %0d %0d %0d",
                           $realtime, "status/found/idx/count/empty = ",
                           got.status, got.found, got.found_index, got.count,
                           got.is_empty);
               fail_count++;
            end else begin
               due = answers_due.pop_front();
               bad = (got.status !== due.status) || (got.found !== due.found) ||
                     (got.found_index !== due.found_index) ||
                     (got.count !== due.count) || (got.is_empty !== due.is_empty);
               if (bad) begin
                  if (fail_count < REPORT_LIMIT) begin
                     $display("%0t: result %0d differs", $realtime, checked_count);
                     $display("   want status=%0d found=%0d idx=%0d count=%0d empty=%0d",
                              due.status, due.found, due.found_index, due.count,
                              due.is_empty);
                     $display("   got  status=%0d found=%0d idx=%0d count=%0d empty=%0d",
                              got.status, got.found, got.found_index, got.count,
                              got.is_empty);
                  end
                  fail_count++;
               end
               checked_count++;
            end
         end
         // command beat updates the shadow list
         if (req_valid && req_ready) begin
            due = apply_list_command(req_data);
            if (due.status == ST_FULL) full_rejects++;
            if (due.status == ST_EMPTY) empty_answers++;
            if (due.found) find_hits++;
            answers_due.push_back(due);
         end
      end
      pending = answers_due.size();
   end

endmodule

// File: verif/ordered_char_list_engine_tb.sv
`timescale 1ns / 1ps
// list engine testbench top: clock, reset, command stimulus, receiver stalls and verdict
module ordered_char_list_engine_tb
   import olst_pkg::*;
();

   localparam int            CAPACITY      = 16;
   localparam int            RANDOM_ITEMS  = 750;
   localparam int            SEGMENTS      = 8;
   localparam int            STALL_LIMIT   = 2000;
   localparam int            SETTLE_CYCLES = 2 * CAPACITY + 10;
   localparam logic [OP_W-1:0] OP_UNUSED   = 3'd7;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int idle_pct     = 0;
   int stall_pct    = 0;
   int quiet_cycles = 0;
   int sent_count   = 0;

   int fail_count;
   int pending;
   int checked_count;
   int full_rejects;
   int empty_answers;
   int find_hits;

   ordered_char_list_engine #(.CAPACITY(CAPACITY)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   olst_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending       (pending),
      .checked_count (checked_count),
      .full_rejects  (full_rejects),
      .empty_answers (empty_answers),
      .find_hits     (find_hits)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles, giving up", $realtime, STALL_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_type make_cmd(input op_type op, input logic [LETTER_W-1:0] letter,
                                        input logic [POS_W-1:0] position);
      req_type cmd;
      cmd.op       = op;
      cmd.letter   = letter;
      cmd.position = position;
      return cmd;
   endfunction

   // random command; mode 0 grows the list, 1 shrinks it, 2 keeps it level
   function automatic req_type pick_command(input int mode);
      int                  roll;
      int                  grow_pct;
      int                  shrink_pct;
      op_type              op;
      logic [LETTER_W-1:0] letter;
      logic [POS_W-1:0]    position;
      grow_pct   = (mode == 0) ? 65 : (mode == 1) ? 20 : 40;
      shrink_pct = (mode == 0) ? 15 : (mode == 1) ? 60 : 35;
      roll = $urandom_range(99);
      if (roll < grow_pct) begin
         case ($urandom_range(2))
            0:       op = OP_APPEND;
            1:       op = OP_PREPEND;
            default: op = OP_INSERT_AT;
         endcase
      end else if (roll < grow_pct + shrink_pct) begin
         case ($urandom_range(2))
            0:       op = OP_REMOVE_LAST;
            1:       op = OP_REMOVE_HEAD;
            default: op = OP_REMOVE_AT;
         endcase
      end else if (roll < 98) begin
         op = OP_FIND;
      end else begin
         op = op_type'(OP_UNUSED);
      end
      // a small alphabet makes searches hit and repeat
      letter = ($urandom_range(1) == 0) ? LETTER_W'(8'h41 + $urandom_range(3))
                                        : LETTER_W'($urandom_range(255));
      position = ($urandom_range(3) != 0) ? POS_W'($urandom_range(17))
                                          : POS_W'($urandom_range(31));
      return make_cmd(op, letter, position);
   endfunction

   // one command beat; called at a rising edge, returns at the accepting edge
   task automatic send_command(input req_type cmd);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= cmd;
      // ready is stable from the falling edge on
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      sent_count++;
   endtask

   // hold off until every owed answer has come back
   task automatic drain_answers();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      @(posedge clock);
   endtask

   initial begin : stimulus
      int seg;
      int n;
      int mode;
      op_type op;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty list corner cases
      send_command(make_cmd(OP_REMOVE_LAST, 8'h00, 5'd0));
      send_command(make_cmd(OP_REMOVE_HEAD, 8'hFF, 5'd0));
      send_command(make_cmd(OP_REMOVE_AT, 8'h00, 5'd31));
      send_command(make_cmd(OP_FIND, 8'h00, 5'd0));
      send_command(make_cmd(op_type'(OP_UNUSED), 8'hFF, 5'd31));
      // positional insert into empty list lands as the only entry
      send_command(make_cmd(OP_INSERT_AT, 8'hFF, 5'd31));

      // fill up to capacity with all three insert flavors
      for (n = 1; n < CAPACITY; n++) begin
         case (n % 3)
            0:       op = OP_APPEND;
            1:       op = OP_PREPEND;
            default: op = OP_INSERT_AT;
         endcase
         send_command(make_cmd(op, LETTER_W'(n * 16 + 2),
                               (n == 5) ? POS_W'(31) : POS_W'(n / 2)));
      end

      // full list rejects, then hit and miss searches
      send_command(make_cmd(OP_APPEND, 8'h00, 5'd0));
      send_command(make_cmd(OP_PREPEND, 8'h00, 5'd0));
      send_command(make_cmd(OP_INSERT_AT, 8'h00, 5'd0));
      send_command(make_cmd(OP_FIND, 8'hFF, 5'd0));
      send_command(make_cmd(OP_FIND, 8'h01, 5'd0));
      drain_answers();

      // random segments rotating through the idle and stall patterns
      for (seg = 0; seg < SEGMENTS; seg++) begin
         case (seg % 4)
            0: begin idle_pct = 0;  stall_pct <= 0;  end
            1: begin idle_pct = 57; stall_pct <= 0;  end
            2: begin idle_pct = 0;  stall_pct <= 57; end
            default: begin idle_pct = 17; stall_pct <= 17; end
         endcase
         mode = (seg * 2) % 3;
         for (n = 0; n < RANDOM_ITEMS / SEGMENTS; n++) send_command(pick_command(mode));
         drain_answers();
      end

      // let any stray beat show up before the verdict
      idle_pct = 0;
      stall_pct <= 0;
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("sent %0d commands, checked %0d answers", sent_count, checked_count);
      $display("full rejects %0d, empty answers %0d, find hits %0d",
               full_rejects, empty_answers, find_hits);
      if (fail_count == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/olst_pkg.sv
rtl/olst_ram.sv
rtl/olst_ctrl.sv
rtl/olst_dp.sv
rtl/ordered_char_list_engine.sv
verif/olst_checker.sv
verif/ordered_char_list_engine_tb.sv
